@@ rtl/asps_pkg.sv @@
// Shared constants, codes and command/status types of the A* path search block.
`timescale 1ns / 1ps
package asps_pkg;
    localparam int ID_W = 6;
    localparam int POS_W = 16;
    localparam int COST_W = 16;
    localparam int G_W = 22;
    localparam int H_W = 17;
    localparam int SQ_W = 2 * H_W;
    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_MAX_DEGREE = 8;

    localparam logic [1:0] ACT_DEF  = 2'd0;
    localparam logic [1:0] ACT_ADD  = 2'd1;
    localparam logic [1:0] ACT_FIND = 2'd2;
    localparam logic [1:0] ACT_NOP  = 2'd3;

    typedef struct packed {
        logic       latch;
        logic       def_wr;
        logic       add_rd;
        logic       add_wr;
        logic       q_init;
        logic       q_goal;
        logic       q_start;
        logic       h_en;
        logic [1:0] h_step;
        logic       h_go;
        logic       h_wr;
        logic       sc_init;
        logic       sc_rd;
        logic       sc_rg;
        logic       sc_cmp;
        logic       rm_init;
        logic       sh_rd;
        logic       sh_wr;
        logic       rm_end;
        logic       e_rd;
        logic       e_nb;
        logic       e_dec;
        logic       p_init;
        logic       p_rd;
        logic       p_wr;
        logic       o_init;
        logic       o_rd;
        logic       o_out;
        logic       o_none;
    } t_cmd;

    typedef struct packed {
        logic [1:0] act;
        logic       q_ok;
        logic       open_empty;
        logic       scan_more;
        logic       is_goal;
        logic       shift_more;
        logic       edge_more;
        logic       take;
        logic       sq_done;
        logic       chain_more;
        logic       emit_last;
    } t_stat;
endpackage

@@ rtl/asps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module asps_ram #(
    parameter int W = 8,
    parameter int D = 64,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] mem [D];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

@@ rtl/asps_isqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module asps_isqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_go,
    input  logic [asps_pkg::SQ_W-1:0] i_val,
    output logic [asps_pkg::H_W-1:0]  o_root,
    output logic                     o_done
);
    localparam int RW = asps_pkg::H_W + 2;
    localparam int XW = asps_pkg::H_W + 4;
    localparam int CW = $clog2(asps_pkg::H_W + 1);

    logic [asps_pkg::SQ_W-1:0] r_val;
    logic [RW-1:0]             r_rem;
    logic [asps_pkg::H_W-1:0]  r_root;
    logic [CW-1:0]             r_step;
    logic                      r_run;
    logic                      r_done;
    logic [XW-1:0]             rem_sh;
    logic [XW-1:0]             trial;
    logic                      ge;

    assign rem_sh = {r_rem, r_val[asps_pkg::SQ_W-1 -: 2]};
    assign trial  = XW'({r_root, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_val  <= i_val;
                r_rem  <= '0;
                r_root <= '0;
                r_step <= CW'(asps_pkg::H_W);
                r_run  <= 1'b1;
            end else if (r_run) begin
                r_val  <= {r_val[asps_pkg::SQ_W-3:0], 2'b00};
                r_rem  <= ge ? RW'(rem_sh - trial) : RW'(rem_sh);
                r_root <= {r_root[asps_pkg::H_W-2:0], ge};
                r_step <= r_step - 1'b1;
                if (r_step == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;
endmodule

@@ rtl/asps_dp.sv @@
// Datapath: graph stores, search state, heuristic arithmetic and result register.
`timescale 1ns / 1ps
module asps_dp #(
    parameter int MAX_NODES  = asps_pkg::DEF_MAX_NODES,
    parameter int MAX_DEGREE = asps_pkg::DEF_MAX_DEGREE
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  asps_pkg::t_cmd             i_cmd,
    output asps_pkg::t_stat            o_stat,
    input  logic [1:0]                 i_action,
    input  logic [asps_pkg::ID_W-1:0]  i_node_id,
    input  logic [asps_pkg::ID_W-1:0]  i_target_id,
    input  logic signed [asps_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [asps_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [asps_pkg::POS_W-1:0] i_pos_z,
    input  logic                       i_passable,
    input  logic [asps_pkg::COST_W-1:0] i_edge_cost,
    output logic                       o_valid,
    output logic [asps_pkg::ID_W-1:0]  o_path_node,
    output logic                       o_found,
    output logic                       o_last
);
    localparam int IW = asps_pkg::ID_W;
    localparam int PW = asps_pkg::POS_W;
    localparam int GW = asps_pkg::G_W;
    localparam int HW = asps_pkg::H_W;
    localparam int NB = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int SLOTS = MAX_NODES * MAX_DEGREE;
    localparam int EA = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int POSR_W = 3 * PW + 1;
    localparam int EDGE_W = IW + asps_pkg::COST_W + 1;
    localparam int GH_W = GW + HW;
    localparam int DX_W = PW + 1;
    localparam logic [IW:0] NODES_L = (IW + 1)'(MAX_NODES);

    // latched input word
    logic [IW-1:0] r_id, r_tgt;
    logic signed [PW-1:0] r_x, r_y, r_z;
    logic r_pass;
    logic [asps_pkg::COST_W-1:0] r_cost;
    // search state
    logic [PW-1:0] r_gx, r_gy, r_gz;
    logic [CW-1:0] r_cnt, r_i, r_bi, r_n, r_k;
    logic [IW-1:0] r_best, r_node, r_nb, r_cur;
    logic [GW:0]   r_best_f;
    logic [GW-1:0] r_best_g, r_g;
    logic [DW-1:0] r_edge_i, r_edge_n;
    logic [asps_pkg::COST_W-1:0] r_ew;
    logic r_eok;
    logic signed [DX_W-1:0] r_dx, r_dy, r_dz;
    logic [asps_pkg::SQ_W-1:0] r_prod, r_acc;
    logic [MAX_NODES-1:0] r_open, r_closed, r_cvld;
    logic r_ov, r_fnd, r_lst;
    logic [IW-1:0] r_pn;

    // memory ports
    logic pos_we, pos_re, cnt_we, cnt_re, edg_we, edg_re, gh_we, gh_re;
    logic par_re, ol_we, ol_re, ch_we, ch_re;
    logic [NB-1:0] pos_ra, cnt_ra, gh_ra, par_ra, ol_wa, ol_ra, ch_wa, ch_ra;
    logic [EA-1:0] edg_wa, edg_ra;
    logic [IW-1:0] ol_wd, ch_wd;
    logic [DW-1:0] cnt_wd;
    logic [POSR_W-1:0] pos_q;
    logic [DW-1:0] cnt_q;
    logic [EDGE_W-1:0] edg_q;
    logic [GH_W-1:0] gh_q;
    logic [IW-1:0] par_q, ol_q, ch_q;

    logic id_ok, tgt_ok, add_ok, nb_in, take, append;
    logic [DW-1:0] cur_cnt;
    logic [CW-1:0] i_nx;
    logic [GW-1:0] g_new, gh_g;
    logic [GW:0] f_val;
    logic [NB-1:0] nbi, besti;
    logic signed [DX_W-1:0] sq_op, dx_n, dy_n, dz_n;
    logic signed [2*DX_W-1:0] sq_full;
    logic [HW-1:0] root;
    logic sq_done;

    assign id_ok  = {1'b0, r_id} < NODES_L;
    assign tgt_ok = {1'b0, r_tgt} < NODES_L;
    assign cur_cnt = r_cvld[r_id[NB-1:0]] ? cnt_q : '0;
    assign add_ok = id_ok && tgt_ok && (cur_cnt < DW'(MAX_DEGREE));
    assign i_nx = r_i + 1'b1;
    assign nbi = r_nb[NB-1:0];
    assign besti = r_best[NB-1:0];
    assign nb_in = {1'b0, r_nb} < NODES_L;
    assign gh_g = gh_q[GH_W-1 -: GW];
    assign g_new = r_best_g + GW'(r_ew);
    assign f_val = {1'b0, gh_g} + (GW + 1)'(gh_q[HW-1:0]);
    assign take = nb_in && !r_closed[nbi] && pos_q[0] && r_eok
        && (!r_open[nbi] || (g_new < gh_g));
    assign append = i_cmd.e_dec && take && !r_open[nbi] && (r_cnt < CW'(MAX_NODES));

    // signed differences against the goal position, straight off the position RAM
    assign dx_n = DX_W'($signed(pos_q[POSR_W-1 -: PW])) - DX_W'($signed(r_gx));
    assign dy_n = DX_W'($signed(pos_q[POSR_W-1-PW -: PW])) - DX_W'($signed(r_gy));
    assign dz_n = DX_W'($signed(pos_q[PW:1])) - DX_W'($signed(r_gz));

    always_comb begin
        case (i_cmd.h_step)
            2'd0:    sq_op = r_dx;
            2'd1:    sq_op = r_dy;
            default: sq_op = r_dz;
        endcase
    end
    assign sq_full = sq_op * sq_op;

    // read and write port selection
    always_comb begin
        pos_we = i_cmd.def_wr && id_ok;
        pos_re = 1'b0;
        pos_ra = r_tgt[NB-1:0];
        if (i_cmd.q_init) begin
            pos_re = 1'b1;
        end else if (i_cmd.q_goal) begin
            pos_re = 1'b1;
            pos_ra = r_id[NB-1:0];
        end else if (i_cmd.e_nb) begin
            pos_re = 1'b1;
            pos_ra = edg_q[EDGE_W-IW +: NB];
        end

        cnt_we = (i_cmd.def_wr && id_ok) || (i_cmd.add_wr && add_ok);
        cnt_wd = i_cmd.def_wr ? '0 : cur_cnt + 1'b1;
        cnt_re = i_cmd.add_rd || i_cmd.rm_init;
        cnt_ra = i_cmd.rm_init ? besti : r_id[NB-1:0];

        edg_we = i_cmd.add_wr && add_ok;
        edg_wa = EA'(r_id[NB-1:0]) * EA'(MAX_DEGREE) + EA'(cur_cnt);
        edg_re = i_cmd.e_rd;
        edg_ra = EA'(besti) * EA'(MAX_DEGREE) + EA'(r_edge_i);

        gh_we = i_cmd.h_wr;
        gh_re = i_cmd.sc_rg || i_cmd.e_nb;
        gh_ra = i_cmd.sc_rg ? ol_q[NB-1:0] : edg_q[EDGE_W-IW +: NB];

        par_re = i_cmd.p_rd;
        par_ra = r_cur[NB-1:0];

        ol_we = 1'b0;
        ol_wa = '0;
        ol_wd = r_id;
        if (i_cmd.q_init) begin
            ol_we = 1'b1;
        end else if (i_cmd.sh_wr) begin
            ol_we = 1'b1;
            ol_wa = r_i[NB-1:0];
            ol_wd = ol_q;
        end else if (append) begin
            ol_we = 1'b1;
            ol_wa = r_cnt[NB-1:0];
            ol_wd = r_nb;
        end
        ol_re = i_cmd.sc_rd || i_cmd.sh_rd;
        ol_ra = i_cmd.sh_rd ? i_nx[NB-1:0] : r_i[NB-1:0];

        ch_we = i_cmd.p_init || i_cmd.p_wr;
        ch_wa = i_cmd.p_wr ? r_n[NB-1:0] : '0;
        ch_wd = i_cmd.p_wr ? par_q : r_tgt;
        ch_re = i_cmd.o_rd;
        ch_ra = r_k[NB-1:0];
    end

    asps_ram #(.W(POSR_W), .D(MAX_NODES)) u_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(r_id[NB-1:0]),
        .i_wdata({r_x, r_y, r_z, r_pass}), .i_re(pos_re), .i_raddr(pos_ra), .o_rdata(pos_q));
    asps_ram #(.W(DW), .D(MAX_NODES)) u_cnt (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(r_id[NB-1:0]), .i_wdata(cnt_wd),
        .i_re(cnt_re), .i_raddr(cnt_ra), .o_rdata(cnt_q));
    asps_ram #(.W(EDGE_W), .D(SLOTS)) u_edge (
        .i_clk(i_clk), .i_we(edg_we), .i_waddr(edg_wa), .i_wdata({r_tgt, r_cost, r_pass}),
        .i_re(edg_re), .i_raddr(edg_ra), .o_rdata(edg_q));
    asps_ram #(.W(GH_W), .D(MAX_NODES)) u_gh (
        .i_clk(i_clk), .i_we(gh_we), .i_waddr(nbi), .i_wdata({r_g, root}),
        .i_re(gh_re), .i_raddr(gh_ra), .o_rdata(gh_q));
    asps_ram #(.W(IW), .D(MAX_NODES)) u_par (
        .i_clk(i_clk), .i_we(gh_we), .i_waddr(nbi), .i_wdata(r_best),
        .i_re(par_re), .i_raddr(par_ra), .o_rdata(par_q));
    asps_ram #(.W(IW), .D(MAX_NODES)) u_open (
        .i_clk(i_clk), .i_we(ol_we), .i_waddr(ol_wa), .i_wdata(ol_wd),
        .i_re(ol_re), .i_raddr(ol_ra), .o_rdata(ol_q));
    asps_ram #(.W(IW), .D(MAX_NODES)) u_chain (
        .i_clk(i_clk), .i_we(ch_we), .i_waddr(ch_wa), .i_wdata(ch_wd),
        .i_re(ch_re), .i_raddr(ch_ra), .o_rdata(ch_q));

    asps_isqrt u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(i_cmd.h_go), .i_val(r_acc),
        .o_root(root), .o_done(sq_done));

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld <= '0;
            r_cnt  <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_ov <= i_cmd.o_out || i_cmd.o_none;
            if (cnt_we) begin
                r_cvld[r_id[NB-1:0]] <= 1'b1;
            end
            if (i_cmd.q_init) begin
                r_cnt <= CW'(1);
            end else if (i_cmd.rm_end) begin
                r_cnt <= r_cnt - 1'b1;
            end else if (append) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_id   <= i_node_id;
            r_tgt  <= i_target_id;
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
            r_z    <= i_pos_z;
            r_pass <= i_passable;
            r_cost <= i_edge_cost;
        end
        if (i_cmd.q_init) begin
            r_open   <= MAX_NODES'(1) << r_id[NB-1:0];
            r_closed <= '0;
        end
        if (i_cmd.q_goal) begin
            r_gx <= pos_q[POSR_W-1 -: PW];
            r_gy <= pos_q[POSR_W-1-PW -: PW];
            r_gz <= pos_q[PW:1];
        end
        if (i_cmd.q_start) begin
            r_dx <= dx_n;
            r_dy <= dy_n;
            r_dz <= dz_n;
            r_nb <= r_id;
            r_g  <= '0;
        end
        if (i_cmd.h_en) begin
            r_prod <= asps_pkg::SQ_W'(sq_full);
            r_acc  <= (i_cmd.h_step == 2'd0) ? '0 : r_acc + r_prod;
        end
        if (i_cmd.sc_init) begin
            r_i <= '0;
        end
        if (i_cmd.sc_rg) begin
            r_node <= ol_q;
        end
        if (i_cmd.sc_cmp) begin
            if (r_i == '0 || f_val < r_best_f) begin
                r_best   <= r_node;
                r_bi     <= r_i;
                r_best_f <= f_val;
                r_best_g <= gh_g;
            end
            r_i <= i_nx;
        end
        if (i_cmd.rm_init) begin
            r_i <= r_bi;
            r_open[besti]   <= 1'b0;
            r_closed[besti] <= 1'b1;
        end
        if (i_cmd.sh_wr) begin
            r_i <= i_nx;
        end
        if (i_cmd.rm_end) begin
            r_edge_n <= r_cvld[besti] ? cnt_q : '0;
            r_edge_i <= '0;
        end
        if (i_cmd.e_rd) begin
            r_edge_i <= r_edge_i + 1'b1;
        end
        if (i_cmd.e_nb) begin
            r_nb  <= edg_q[EDGE_W-1 -: IW];
            r_ew  <= edg_q[asps_pkg::COST_W:1];
            r_eok <= edg_q[0];
        end
        if (i_cmd.e_dec && take) begin
            r_open[nbi] <= 1'b1;
            r_g  <= g_new;
            r_dx <= dx_n;
            r_dy <= dy_n;
            r_dz <= dz_n;
        end
        if (i_cmd.p_init) begin
            r_n   <= CW'(1);
            r_cur <= r_tgt;
        end
        if (i_cmd.p_wr) begin
            r_cur <= par_q;
            r_n   <= r_n + 1'b1;
        end
        if (i_cmd.o_init) begin
            r_k <= r_n - 1'b1;
        end
        if (i_cmd.o_out) begin
            r_pn  <= ch_q;
            r_fnd <= 1'b1;
            r_lst <= (r_k == '0);
            r_k   <= r_k - 1'b1;
        end
        if (i_cmd.o_none) begin
            r_pn  <= '0;
            r_fnd <= 1'b0;
            r_lst <= 1'b1;
        end
    end

    always_comb begin
        o_stat.act        = i_action;
        o_stat.q_ok       = ({1'b0, i_node_id} < NODES_L) && ({1'b0, i_target_id} < NODES_L);
        o_stat.open_empty = (r_cnt == '0);
        o_stat.scan_more  = i_nx < r_cnt;
        o_stat.is_goal    = (r_best == r_tgt);
        o_stat.shift_more = i_nx < r_cnt;
        o_stat.edge_more  = r_edge_i < r_edge_n;
        o_stat.take       = take;
        o_stat.sq_done    = sq_done;
        o_stat.chain_more = (r_cur != r_id) && (r_n < CW'(MAX_NODES));
        o_stat.emit_last  = (r_k == '0);
    end

    assign o_valid     = r_ov;
    assign o_path_node = r_pn;
    assign o_found     = r_fnd;
    assign o_last      = r_lst;

    a_nopath_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> o_last)
        else $error("no-path word without last mark");
    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_NODES))
        else $error("open list count beyond node count");
endmodule

@@ rtl/asps_ctrl.sv @@
// Controller state machine that sequences define, add-edge and search work.
`timescale 1ns / 1ps
module asps_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  asps_pkg::t_stat i_stat,
    output asps_pkg::t_cmd  o_cmd
);
    localparam int SN = 33;

    typedef enum logic [SN-1:0] {
        ST_IDLE    = SN'(1) << 0,
        ST_DEF     = SN'(1) << 1,
        ST_ADD_RD  = SN'(1) << 2,
        ST_ADD_WR  = SN'(1) << 3,
        ST_Q_INIT  = SN'(1) << 4,
        ST_Q_GOAL  = SN'(1) << 5,
        ST_Q_START = SN'(1) << 6,
        ST_H_M0    = SN'(1) << 7,
        ST_H_M1    = SN'(1) << 8,
        ST_H_M2    = SN'(1) << 9,
        ST_H_M3    = SN'(1) << 10,
        ST_H_GO    = SN'(1) << 11,
        ST_H_WAIT  = SN'(1) << 12,
        ST_SC_INIT = SN'(1) << 13,
        ST_SC_RD   = SN'(1) << 14,
        ST_SC_RG   = SN'(1) << 15,
        ST_SC_CMP  = SN'(1) << 16,
        ST_SC_DONE = SN'(1) << 17,
        ST_RM_INIT = SN'(1) << 18,
        ST_SH_CHK  = SN'(1) << 19,
        ST_SH_RD   = SN'(1) << 20,
        ST_SH_WR   = SN'(1) << 21,
        ST_RM_END  = SN'(1) << 22,
        ST_E_CHK   = SN'(1) << 23,
        ST_E_NB    = SN'(1) << 24,
        ST_E_DEC   = SN'(1) << 25,
        ST_P_INIT  = SN'(1) << 26,
        ST_P_CHK   = SN'(1) << 27,
        ST_P_RD    = SN'(1) << 28,
        ST_P_WR    = SN'(1) << 29,
        ST_O_RD    = SN'(1) << 30,
        ST_O_OUT   = SN'(1) << 31,
        ST_NONE    = SN'(1) << 32
    } t_state;

    t_state r_state, n_state;
    logic r_ctx, n_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ctx   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ctx   <= n_ctx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ctx   = r_ctx;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    case (i_stat.act)
                        asps_pkg::ACT_DEF:  n_state = ST_DEF;
                        asps_pkg::ACT_ADD:  n_state = ST_ADD_RD;
                        asps_pkg::ACT_FIND: n_state = i_stat.q_ok ? ST_Q_INIT : ST_NONE;
                        default:            n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DEF: begin
                o_cmd.def_wr = 1'b1;
                n_state = ST_IDLE;
            end
            ST_ADD_RD: begin
                o_cmd.add_rd = 1'b1;
                n_state = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                o_cmd.add_wr = 1'b1;
                n_state = ST_IDLE;
            end
            ST_Q_INIT: begin
                o_cmd.q_init = 1'b1;
                n_state = ST_Q_GOAL;
            end
            ST_Q_GOAL: begin
                o_cmd.q_goal = 1'b1;
                n_state = ST_Q_START;
            end
            ST_Q_START: begin
                o_cmd.q_start = 1'b1;
                n_ctx = 1'b1;
                n_state = ST_H_M0;
            end
            ST_H_M0: begin
                o_cmd.h_en = 1'b1;
                o_cmd.h_step = 2'd0;
                n_state = ST_H_M1;
            end
            ST_H_M1: begin
                o_cmd.h_en = 1'b1;
                o_cmd.h_step = 2'd1;
                n_state = ST_H_M2;
            end
            ST_H_M2: begin
                o_cmd.h_en = 1'b1;
                o_cmd.h_step = 2'd2;
                n_state = ST_H_M3;
            end
            ST_H_M3: begin
                o_cmd.h_en = 1'b1;
                o_cmd.h_step = 2'd3;
                n_state = ST_H_GO;
            end
            ST_H_GO: begin
                o_cmd.h_go = 1'b1;
                n_state = ST_H_WAIT;
            end
            ST_H_WAIT: begin
                if (i_stat.sq_done) begin
                    o_cmd.h_wr = 1'b1;
                    n_state = r_ctx ? ST_SC_INIT : ST_E_CHK;
                end
            end
            ST_SC_INIT: begin
                o_cmd.sc_init = 1'b1;
                n_state = i_stat.open_empty ? ST_NONE : ST_SC_RD;
            end
            ST_SC_RD: begin
                o_cmd.sc_rd = 1'b1;
                n_state = ST_SC_RG;
            end
            ST_SC_RG: begin
                o_cmd.sc_rg = 1'b1;
                n_state = ST_SC_CMP;
            end
            ST_SC_CMP: begin
                o_cmd.sc_cmp = 1'b1;
                n_state = i_stat.scan_more ? ST_SC_RD : ST_SC_DONE;
            end
            ST_SC_DONE: begin
                n_state = i_stat.is_goal ? ST_P_INIT : ST_RM_INIT;
            end
            ST_RM_INIT: begin
                o_cmd.rm_init = 1'b1;
                n_state = ST_SH_CHK;
            end
            ST_SH_CHK: begin
                n_state = i_stat.shift_more ? ST_SH_RD : ST_RM_END;
            end
            ST_SH_RD: begin
                o_cmd.sh_rd = 1'b1;
                n_state = ST_SH_WR;
            end
            ST_SH_WR: begin
                o_cmd.sh_wr = 1'b1;
                n_state = ST_SH_CHK;
            end
            ST_RM_END: begin
                o_cmd.rm_end = 1'b1;
                n_state = ST_E_CHK;
            end
            ST_E_CHK: begin
                if (i_stat.edge_more) begin
                    o_cmd.e_rd = 1'b1;
                    n_state = ST_E_NB;
                end else begin
                    n_state = ST_SC_INIT;
                end
            end
            ST_E_NB: begin
                o_cmd.e_nb = 1'b1;
                n_state = ST_E_DEC;
            end
            ST_E_DEC: begin
                o_cmd.e_dec = 1'b1;
                if (i_stat.take) begin
                    n_ctx = 1'b0;
                    n_state = ST_H_M0;
                end else begin
                    n_state = ST_E_CHK;
                end
            end
            ST_P_INIT: begin
                o_cmd.p_init = 1'b1;
                n_state = ST_P_CHK;
            end
            ST_P_CHK: begin
                if (i_stat.chain_more) begin
                    n_state = ST_P_RD;
                end else begin
                    o_cmd.o_init = 1'b1;
                    n_state = ST_O_RD;
                end
            end
            ST_P_RD: begin
                o_cmd.p_rd = 1'b1;
                n_state = ST_P_WR;
            end
            ST_P_WR: begin
                o_cmd.p_wr = 1'b1;
                n_state = ST_P_CHK;
            end
            ST_O_RD: begin
                o_cmd.o_rd = 1'b1;
                n_state = ST_O_OUT;
            end
            ST_O_OUT: begin
                o_cmd.o_out = 1'b1;
                n_state = i_stat.emit_last ? ST_IDLE : ST_O_RD;
            end
            ST_NONE: begin
                o_cmd.o_none = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_stat.act != asps_pkg::ACT_NOP) |=> busy)
        else $error("accepted word did not make the block busy");
    a_sqrt_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_H_WAIT && i_stat.sq_done) |=>
        (r_state == ST_SC_INIT || r_state == ST_E_CHK))
        else $error("heuristic finish went to a wrong state");
endmodule

@@ rtl/a_star_path_search.sv @@
// Top level of the A* path search block: controller plus datapath.
// Define node runs through ST_DEF, add edge through ST_ADD_RD and ST_ADD_WR, then busy drops.
// A query scans the open list for each pick, shifts the entries behind a removed one,
// visits edges and runs a heuristic for the start and each taken node (4 multiply-accumulate
// steps, a launch, a 17-step root and one to store it), then walks the path and emits words.
// One item at a time. Reset is synchronous, active low; it clears control state
// and edge counts. Results come as one-cycle o_valid strobes that cannot be stalled.
`timescale 1ns / 1ps
module a_star_path_search #(
    parameter int MAX_NODES  = asps_pkg::DEF_MAX_NODES,
    parameter int MAX_DEGREE = asps_pkg::DEF_MAX_DEGREE
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_action,
    input  logic [asps_pkg::ID_W-1:0]  i_node_id,
    input  logic [asps_pkg::ID_W-1:0]  i_target_id,
    input  logic signed [asps_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [asps_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [asps_pkg::POS_W-1:0] i_pos_z,
    input  logic                       i_passable,
    input  logic [asps_pkg::COST_W-1:0] i_edge_cost,
    output logic                       o_valid,
    output logic [asps_pkg::ID_W-1:0]  o_path_node,
    output logic                       o_found,
    output logic                       o_last
);
    // command and status between the sequencer and the datapath
    asps_pkg::t_cmd  cmd;
    asps_pkg::t_stat stat;

    // sequencer: one state per step of define, add, search and path walk
    asps_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_stat (stat),
        .o_cmd  (cmd)
    );

    // datapath: graph RAMs, open list, heuristic unit and result register
    asps_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_DEGREE(MAX_DEGREE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_action   (i_action),
        .i_node_id  (i_node_id),
        .i_target_id(i_target_id),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .i_passable (i_passable),
        .i_edge_cost(i_edge_cost),
        .o_valid    (o_valid),
        .o_path_node(o_path_node),
        .o_found    (o_found),
        .o_last     (o_last)
    );
endmodule

@@ bench/tb_a_star_path_search.sv @@
// Self-checking bench for the A* path search block: graph build, path queries, word checks.
`timescale 1ns / 1ps
module tb_a_star_path_search;
    localparam int NODES     = asps_pkg::DEF_MAX_NODES;
    localparam int DEGREE    = asps_pkg::DEF_MAX_DEGREE;
    localparam int IDW       = asps_pkg::ID_W;
    localparam int PW        = asps_pkg::POS_W;
    localparam int CSW       = asps_pkg::COST_W;
    localparam int RAND_CMDS = 380;
    localparam int LIMIT     = 20000000;

    typedef struct {
        logic [1:0]           act;
        logic [IDW-1:0]       id;
        logic [IDW-1:0]       tgt;
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] z;
        logic                 pass;
        logic [CSW-1:0]       cost;
    } t_item;

    typedef struct {
        logic [IDW-1:0] node;
        logic           found;
        logic           last;
    } t_word;

    // Scoreboard: mirrors the graph store and runs the search on every query.
    class path_board;
        int                   px[NODES], py[NODES], pz[NODES];
        bit                   pok[NODES];
        int unsigned          deg[NODES];
        logic [IDW-1:0]       edst[NODES*DEGREE];
        int unsigned          ewt[NODES*DEGREE];
        bit                   eok[NODES*DEGREE];
        t_word                exp_words[$];
        int                   errors, queries, paths, misses, words;

        function longint unsigned int_root(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function int unsigned dist_est(int a, int b);
            longint dx, dy, dz;
            dx = px[a] - px[b];
            dy = py[a] - py[b];
            dz = pz[a] - pz[b];
            return 32'(int_root(dx * dx + dy * dy + dz * dz));
        endfunction

        function void push_word(logic [IDW-1:0] n, logic f, logic l);
            t_word w;
            w.node = n; w.found = f; w.last = l;
            exp_words.push_back(w);
        endfunction

        function void run_search(int s, int goal);
            int unsigned g[NODES], h[NODES];
            bit          inopen[NODES], closed[NODES];
            int          par[NODES];
            int          olist[$];
            int          chain[$];
            int          bi, best, cur, slot, nb;
            int unsigned ng;
            queries++;
            foreach (g[i]) begin
                g[i] = 0; h[i] = 0; inopen[i] = 0; closed[i] = 0; par[i] = 0;
            end
            olist.push_back(s);
            inopen[s] = 1;
            h[s] = dist_est(s, goal);
            while (olist.size() != 0) begin
                bi = 0;
                for (int i = 1; i < olist.size(); i++)
                    if (g[olist[i]] + h[olist[i]] < g[olist[bi]] + h[olist[bi]]) bi = i;
                best = olist[bi];
                if (best == goal) begin
                    cur = best;
                    chain.push_front(cur);
                    while (cur != s && chain.size() < NODES) begin
                        cur = par[cur];
                        chain.push_front(cur);
                    end
                    foreach (chain[k])
                        push_word(IDW'(chain[k]), 1'b1, k == chain.size() - 1);
                    paths++;
                    return;
                end
                olist.delete(bi);
                inopen[best] = 0;
                closed[best] = 1;
                for (int i = 0; i < deg[best] && i < DEGREE; i++) begin
                    slot = best * DEGREE + i;
                    nb = edst[slot];
                    if (closed[nb] || !pok[nb] || !eok[slot]) continue;
                    ng = g[best] + ewt[slot];
                    if (!inopen[nb]) begin
                        olist.push_back(nb);
                        inopen[nb] = 1;
                    end else if (ng >= g[nb]) begin
                        continue;
                    end
                    par[nb] = best;
                    g[nb] = ng;
                    h[nb] = dist_est(nb, goal);
                end
            end
            misses++;
            push_word('0, 1'b0, 1'b1);
        endfunction

        function void note_item(t_item c);
            int slot;
            case (c.act)
                asps_pkg::ACT_DEF: begin
                    px[c.id] = c.x; py[c.id] = c.y; pz[c.id] = c.z;
                    pok[c.id] = c.pass;
                    deg[c.id] = 0;
                end
                asps_pkg::ACT_ADD: begin
                    if (deg[c.id] < DEGREE) begin
                        slot = c.id * DEGREE + deg[c.id];
                        edst[slot] = c.tgt;
                        ewt[slot]  = c.cost;
                        eok[slot]  = c.pass;
                        deg[c.id]++;
                    end
                end
                asps_pkg::ACT_FIND: run_search(c.id, c.tgt);
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task check_word(logic [IDW-1:0] n, logic f, logic l);
            t_word w;
            words++;
            if (exp_words.size() == 0) begin
                report($sformatf("unexpected word node=%0d found=%0b last=%0b", n, f, l));
                return;
            end
            w = exp_words.pop_front();
            if (n !== w.node || f !== w.found || l !== w.last)
                report($sformatf("got node=%0d found=%0b last=%0b, want %0d/%0b/%0b",
                                 n, f, l, w.node, w.found, w.last));
        endtask

        function int pending();
            return exp_words.size();
        endfunction
    endclass

    logic                 i_clk, i_rst_n, start, busy;
    logic [1:0]           i_action;
    logic [IDW-1:0]       i_node_id, i_target_id;
    logic signed [PW-1:0] i_pos_x, i_pos_y, i_pos_z;
    logic                 i_passable;
    logic [CSW-1:0]       i_edge_cost;
    logic                 o_valid;
    logic [IDW-1:0]       o_path_node;
    logic                 o_found, o_last;

    path_board sb = new;
    int        sent, cycles;
    bit        quiet, defined[NODES];
    int        def_ids[$];

    a_star_path_search i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_node_id(i_node_id), .i_target_id(i_target_id),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_passable(i_passable), .i_edge_cost(i_edge_cost),
        .o_valid(o_valid), .o_path_node(o_path_node), .o_found(o_found), .o_last(o_last)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid) sb.check_word(o_path_node, o_found, o_last);

    function automatic t_item mk(int a, int id, int tgt, int x, int y, int z,
                                 int p, int c);
        t_item m;
        m.act = 2'(a); m.id = IDW'(id); m.tgt = IDW'(tgt);
        m.x = PW'(x); m.y = PW'(y); m.z = PW'(z);
        m.pass = 1'(p); m.cost = CSW'(c);
        return m;
    endfunction

    // Every field random; callers override what the action uses.
    function automatic t_item noise_cmd();
        return mk($urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom, $urandom, $urandom, $urandom_range(0, 1), $urandom);
    endfunction

    // Drive one word at the falling edge; hold until the block takes it.
    task automatic send(t_item c);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            start = 0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_action = c.act; i_node_id = c.id; i_target_id = c.tgt;
        i_pos_x = c.x; i_pos_y = c.y; i_pos_z = c.z;
        i_passable = c.pass; i_edge_cost = c.cost;
        start = 1;
        do @(posedge i_clk); while (busy);
        sent++;
        sb.note_item(c);
        if (c.act == asps_pkg::ACT_DEF && !defined[c.id]) begin
            defined[c.id] = 1;
            def_ids.push_back(c.id);
        end
        @(negedge i_clk);
    endtask

    // Drop start and hold off until every queued word has arrived.
    task automatic drain();
        start = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic build_and_query();
        int    pool[$];
        int    n;
        bit    wide;
        t_item c;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(2, 8);
        wide = $urandom_range(0, 4) == 0;
        for (int i = 0; i < n; i++) begin
            c = noise_cmd();
            c.act = asps_pkg::ACT_DEF;
            if (!wide) begin
                c.x = PW'($urandom_range(0, 100) - 50);
                c.y = PW'($urandom_range(0, 100) - 50);
                c.z = PW'($urandom_range(0, 20) - 10);
            end
            c.pass = $urandom_range(0, 7) != 0;
            pool.push_back(c.id);
            send(c);
        end
        repeat (n * $urandom_range(1, 3)) begin
            c = noise_cmd();
            c.act = asps_pkg::ACT_ADD;
            c.id  = IDW'(pool[$urandom_range(0, pool.size() - 1)]);
            c.tgt = IDW'(def_ids[$urandom_range(0, def_ids.size() - 1)]);
            if ($urandom_range(0, 3) != 0) c.cost = CSW'($urandom_range(0, 120));
            c.pass = $urandom_range(0, 9) != 0;
            send(c);
        end
        repeat ($urandom_range(2, 5)) begin
            c = noise_cmd();
            c.act = asps_pkg::ACT_FIND;
            c.id  = ($urandom_range(0, 1) != 0)
                    ? IDW'(pool[$urandom_range(0, pool.size() - 1)])
                    : IDW'(def_ids[$urandom_range(0, def_ids.size() - 1)]);
            c.tgt = ($urandom_range(0, 9) == 0)
                    ? c.id
                    : IDW'(def_ids[$urandom_range(0, def_ids.size() - 1)]);
            send(c);
        end
        if ($urandom_range(0, 3) == 0) begin
            c = noise_cmd();
            c.act = asps_pkg::ACT_NOP;
            send(c);
        end
    endtask

    initial begin
        bit pressed;
        start = 0; i_rst_n = 0;
        sent = 0; quiet = 0; pressed = 0;
        i_action = asps_pkg::ACT_NOP; i_node_id = '0; i_target_id = '0;
        i_pos_x = '0; i_pos_y = '0; i_pos_z = '0; i_passable = 0; i_edge_cost = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Directed: coordinate extremes, cost extremes, blocked node and edge,
        // start equal to target, unreachable target, unused action, full edge list.
        send(mk(asps_pkg::ACT_DEF, 0, 9, 0, 0, 0, 1, 0));
        send(mk(asps_pkg::ACT_DEF, 1, 0, 32767, 32767, 32767, 1, 65535));
        send(mk(asps_pkg::ACT_DEF, 2, 0, -32768, -32768, -32768, 1, 0));
        send(mk(asps_pkg::ACT_DEF, 3, 0, 3, 4, 0, 0, 0));
        send(mk(asps_pkg::ACT_DEF, 63, 63, -1, 5, -7, 1, 0));
        send(mk(asps_pkg::ACT_ADD, 0, 1, 0, 0, 0, 1, 65535));
        send(mk(asps_pkg::ACT_ADD, 0, 3, 0, 0, 0, 1, 0));
        send(mk(asps_pkg::ACT_ADD, 1, 2, 0, 0, 0, 1, 0));
        send(mk(asps_pkg::ACT_ADD, 0, 2, 0, 0, 0, 0, 10));
        send(mk(asps_pkg::ACT_ADD, 0, 63, 0, 0, 0, 1, 0));
        send(mk(asps_pkg::ACT_ADD, 63, 2, 0, 0, 0, 1, 1));
        send(mk(asps_pkg::ACT_FIND, 0, 2, 0, 0, 0, 0, 0));
        send(mk(asps_pkg::ACT_FIND, 0, 0, 0, 0, 0, 0, 0));
        send(mk(asps_pkg::ACT_FIND, 3, 3, 0, 0, 0, 0, 0));
        send(mk(asps_pkg::ACT_FIND, 2, 0, 0, 0, 0, 0, 0));
        send(mk(asps_pkg::ACT_FIND, 0, 3, 0, 0, 0, 0, 0));
        send(mk(asps_pkg::ACT_NOP, 63, 63, -1, -1, -1, 1, 65535));
        for (int i = 0; i < DEGREE; i++) send(mk(asps_pkg::ACT_ADD, 63, 1, 0, 0, 0, 1, i));
        send(mk(asps_pkg::ACT_FIND, 63, 1, 0, 0, 0, 0, 0));

        while (sent < RAND_CMDS) begin
            quiet = sent > RAND_CMDS * 85 / 100;
            build_and_query();
            if (!pressed && sent > RAND_CMDS / 2) begin
                pressed = 1;
                drain();
            end
        end
        drain();
        $display("Sent %0d words; %0d queries gave %0d paths, %0d misses, %0d result words.",
                 sent, sb.queries, sb.paths, sb.misses, sb.words);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

@@ a_star_path_search.f @@
rtl/asps_pkg.sv
rtl/asps_ram.sv
rtl/asps_isqrt.sv
rtl/asps_dp.sv
rtl/asps_ctrl.sv
rtl/a_star_path_search.sv
bench/tb_a_star_path_search.sv
